>>> design/rlpm_pkg.sv
// Shared types and constants for the range list parse and match core.
package rlpm_pkg;

	localparam int unsigned QUERY_W = 63;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned NUM_W   = 31;
	localparam int unsigned BOUND_W = 32;

	localparam logic [NUM_W-1:0] NUM_LIMIT = 31'h7fff_ffff;

	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_COMMA = 8'd44;
	localparam logic [7:0] CHAR_DASH  = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	typedef enum logic [1:0] {
		CMD_CHAR  = 2'd0,
		CMD_END   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_e_t;

	typedef enum logic [2:0] {
		PH_LOW_WS   = 3'd0,
		PH_LOW_DIG  = 3'd1,
		PH_LOW_END  = 3'd2,
		PH_DASH     = 3'd3,
		PH_HIGH_WS  = 3'd4,
		PH_HIGH_DIG = 3'd5,
		PH_HIGH_END = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_EMIT = 2'd2
	} ctl_state_t;

	typedef struct packed {
		logic exec_char;
		logic exec_end;
		logic scan_start;
		logic scan_step;
		logic res_load;
		logic res_value;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic filter_on;
		logic table_empty;
		logic cmp_valid;
		logic hit;
		logic cmp_last;
	} dp_status_t;

endpackage

>>> design/rlpm_ctrl.sv
// Controller state machine: sequences list characters, list ends and table scans.
module rlpm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [1:0]           command,
	output logic                 result_valid,
	input  logic                 result_stall,
	input  rlpm_pkg::dp_status_t status,
	output rlpm_pkg::dp_cmd_t    cmd
);

	rlpm_pkg::ctl_state_t state_q, state_nxt;
	logic                 out_valid_q;
	logic                 accept;
	logic                 slot_free;
	logic                 scan_done;

	assign item_stall   = (state_q != rlpm_pkg::ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign slot_free    = !out_valid_q || !result_stall;
	assign scan_done    = status.cmp_valid && (status.hit || status.cmp_last);
	assign result_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rlpm_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						rlpm_pkg::CMD_END: state_nxt = rlpm_pkg::ST_EMIT;
						rlpm_pkg::CMD_QUERY: begin
							if (status.filter_on && !status.table_empty)
								state_nxt = rlpm_pkg::ST_SCAN;
							else
								state_nxt = rlpm_pkg::ST_EMIT;
						end
						default: state_nxt = rlpm_pkg::ST_IDLE;
					endcase
				end
			end
			rlpm_pkg::ST_SCAN: begin
				if (scan_done)
					state_nxt = rlpm_pkg::ST_EMIT;
			end
			rlpm_pkg::ST_EMIT: begin
				if (slot_free)
					state_nxt = rlpm_pkg::ST_IDLE;
			end
			default: state_nxt = rlpm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			rlpm_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						rlpm_pkg::CMD_CHAR: cmd.exec_char = 1'b1;
						rlpm_pkg::CMD_END: begin
							cmd.exec_end  = 1'b1;
							cmd.res_load  = 1'b1;
							cmd.res_value = 1'b0;
						end
						rlpm_pkg::CMD_QUERY: begin
							if (status.filter_on && !status.table_empty) begin
								cmd.scan_start = 1'b1;
							end else begin
								cmd.res_load  = 1'b1;
								cmd.res_value = !status.filter_on;
							end
						end
						default: cmd = '0;
					endcase
				end
			end
			rlpm_pkg::ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (scan_done) begin
					cmd.res_load  = 1'b1;
					cmd.res_value = status.hit;
				end
			end
			rlpm_pkg::ST_EMIT: cmd.out_load = slot_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rlpm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> design/rlpm_datapath.sv
// Datapath: list parser, range table memory, scan comparator and result register.
module rlpm_datapath #(
	parameter int unsigned MAX_RANGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlpm_pkg::dp_cmd_t             cmd,
	output rlpm_pkg::dp_status_t          status,
	input  logic                          filter_enable_we,
	input  logic                          filter_enable_wdata,
	input  logic [7:0]                    list_char,
	input  logic [rlpm_pkg::QUERY_W-1:0]  query_value,
	output logic                          in_range,
	output logic                          table_overflow,
	output logic [rlpm_pkg::COUNT_W-1:0]  range_count
);

	localparam int unsigned CNT_W = $clog2(MAX_RANGES + 1);
	localparam int unsigned AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned EXT_W = (CNT_W > rlpm_pkg::COUNT_W) ? CNT_W : rlpm_pkg::COUNT_W;
	localparam int unsigned NW    = rlpm_pkg::NUM_W;
	localparam int unsigned BW    = rlpm_pkg::BOUND_W;
	localparam int unsigned QW    = rlpm_pkg::QUERY_W;

	// Range table; entries at or above the stored count are never compared.
	logic [BW-1:0] mem_lo [MAX_RANGES];
	logic [BW-1:0] mem_hi [MAX_RANGES];

	logic                   filter_q;
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic [NW-1:0]          acc_q;
	logic [NW-1:0]          low_q;
	rlpm_pkg::phase_t       phase_q;
	logic                   closed_q;

	logic [QW-1:0]          query_q;
	logic [CNT_W-1:0]       scan_idx_q;
	logic                   rd_valid_s1;
	logic                   rd_last_s1;
	logic [BW-1:0]          rd_lo_s1;
	logic [BW-1:0]          rd_hi_s1;
	logic                   rd_issue;

	logic                   match_q;
	logic                   in_range_q;
	logic                   table_overflow_q;
	logic [rlpm_pkg::COUNT_W-1:0] range_count_q;

	// Parser working values, with a new list opened where the last one was closed.
	logic [CNT_W-1:0]       cnt_b;
	logic                   ovf_b;
	logic [NW-1:0]          acc_b;
	logic [NW-1:0]          low_b;
	rlpm_pkg::phase_t       ph_b;

	logic                   is_digit;
	logic                   is_space;
	logic [NW-1:0]          digit_val;
	logic [NW+3:0]          acc_x10;
	logic [NW-1:0]          acc_dig;
	logic                   finish;
	logic                   room;
	logic [BW-1:0]          fin_lo;
	logic [BW-1:0]          fin_hi;
	logic [NW-1:0]          acc_nxt;
	logic [NW-1:0]          low_nxt;
	rlpm_pkg::phase_t       ph_nxt;
	logic                   parse_en;
	logic [EXT_W-1:0]       count_ext;

	assign parse_en = cmd.exec_char || cmd.exec_end;

	assign cnt_b = closed_q ? '0 : count_q;
	assign ovf_b = closed_q ? 1'b0 : ovf_q;
	assign acc_b = closed_q ? '0 : acc_q;
	assign low_b = closed_q ? '0 : low_q;
	assign ph_b  = closed_q ? rlpm_pkg::PH_LOW_WS : phase_q;

	assign is_digit  = (list_char inside {[rlpm_pkg::CHAR_ZERO:rlpm_pkg::CHAR_NINE]});
	assign is_space  = (list_char == rlpm_pkg::CHAR_SPACE) ||
		(list_char inside {[rlpm_pkg::CHAR_TAB:rlpm_pkg::CHAR_CR]});
	assign digit_val = NW'(list_char - rlpm_pkg::CHAR_ZERO);

	// Ten times the accumulator as two shifts and an add, saturated at the number limit.
	assign acc_x10 = ({4'b0, acc_b} << 3) + ({4'b0, acc_b} << 1) + (NW + 4)'(digit_val[3:0]);
	assign acc_dig = (acc_x10 > (NW + 4)'(rlpm_pkg::NUM_LIMIT)) ? rlpm_pkg::NUM_LIMIT
		: acc_x10[NW-1:0];

	assign finish = cmd.exec_end || (cmd.exec_char && (list_char == rlpm_pkg::CHAR_COMMA));
	assign room   = (cnt_b < CNT_W'(MAX_RANGES));

	always_comb begin
		case (ph_b)
			rlpm_pkg::PH_LOW_WS, rlpm_pkg::PH_LOW_DIG, rlpm_pkg::PH_LOW_END: begin
				fin_lo = {1'b0, acc_b};
				fin_hi = {1'b0, acc_b} + BW'(1);
			end
			rlpm_pkg::PH_DASH: begin
				fin_lo = {1'b0, low_b};
				fin_hi = {1'b0, low_b};
			end
			default: begin
				fin_lo = {1'b0, low_b};
				fin_hi = {1'b0, acc_b} + BW'(1);
			end
		endcase
	end

	always_comb begin
		acc_nxt = acc_b;
		low_nxt = low_b;
		ph_nxt  = ph_b;
		if (finish) begin
			acc_nxt = '0;
			low_nxt = '0;
			ph_nxt  = rlpm_pkg::PH_LOW_WS;
		end else begin
			case (ph_b)
				rlpm_pkg::PH_LOW_WS: begin
					if (is_space) begin
						ph_nxt = rlpm_pkg::PH_LOW_WS;
					end else if (list_char == rlpm_pkg::CHAR_PLUS) begin
						ph_nxt = rlpm_pkg::PH_LOW_DIG;
					end else if (is_digit) begin
						acc_nxt = digit_val;
						ph_nxt  = rlpm_pkg::PH_LOW_DIG;
					end else if (list_char == rlpm_pkg::CHAR_DASH) begin
						low_nxt = acc_b;
						acc_nxt = '0;
						ph_nxt  = rlpm_pkg::PH_DASH;
					end else begin
						ph_nxt = rlpm_pkg::PH_LOW_END;
					end
				end
				rlpm_pkg::PH_LOW_DIG: begin
					if (is_digit) begin
						acc_nxt = acc_dig;
					end else if (list_char == rlpm_pkg::CHAR_DASH) begin
						low_nxt = acc_b;
						acc_nxt = '0;
						ph_nxt  = rlpm_pkg::PH_DASH;
					end else begin
						ph_nxt = rlpm_pkg::PH_LOW_END;
					end
				end
				rlpm_pkg::PH_LOW_END: begin
					if (list_char == rlpm_pkg::CHAR_DASH) begin
						low_nxt = acc_b;
						acc_nxt = '0;
						ph_nxt  = rlpm_pkg::PH_DASH;
					end
				end
				rlpm_pkg::PH_DASH, rlpm_pkg::PH_HIGH_WS: begin
					if (is_space) begin
						ph_nxt = rlpm_pkg::PH_HIGH_WS;
					end else if (list_char == rlpm_pkg::CHAR_PLUS) begin
						ph_nxt = rlpm_pkg::PH_HIGH_DIG;
					end else if (is_digit) begin
						acc_nxt = digit_val;
						ph_nxt  = rlpm_pkg::PH_HIGH_DIG;
					end else begin
						ph_nxt = rlpm_pkg::PH_HIGH_END;
					end
				end
				rlpm_pkg::PH_HIGH_DIG: begin
					if (is_digit)
						acc_nxt = acc_dig;
					else
						ph_nxt = rlpm_pkg::PH_HIGH_END;
				end
				default: ph_nxt = rlpm_pkg::PH_HIGH_END;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= 1'b0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			acc_q    <= '0;
			low_q    <= '0;
			phase_q  <= rlpm_pkg::PH_LOW_WS;
			closed_q <= 1'b1;
		end else begin
			if (filter_enable_we)
				filter_q <= filter_enable_wdata;
			if (parse_en) begin
				acc_q    <= acc_nxt;
				low_q    <= low_nxt;
				phase_q  <= ph_nxt;
				closed_q <= cmd.exec_end;
				if (finish && room)
					count_q <= cnt_b + CNT_W'(1);
				else
					count_q <= cnt_b;
				ovf_q <= ovf_b || (finish && !room);
			end
		end
	end

	assign rd_issue = cmd.scan_step && (scan_idx_q < count_q);

	always_ff @(posedge clk) begin
		if (parse_en && finish && room) begin
			mem_lo[cnt_b[AW-1:0]] <= fin_lo;
			mem_hi[cnt_b[AW-1:0]] <= fin_hi;
		end
		rd_lo_s1 <= mem_lo[scan_idx_q[AW-1:0]];
		rd_hi_s1 <= mem_hi[scan_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				scan_idx_q  <= '0;
				rd_valid_s1 <= 1'b0;
				rd_last_s1  <= 1'b0;
			end else begin
				rd_valid_s1 <= rd_issue;
				rd_last_s1  <= rd_issue && ((scan_idx_q + CNT_W'(1)) == count_q);
				if (rd_issue)
					scan_idx_q <= scan_idx_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start)
			query_q <= query_value;
		if (cmd.res_load)
			match_q <= cmd.res_value;
		if (cmd.out_load) begin
			in_range_q       <= match_q;
			table_overflow_q <= ovf_q;
			range_count_q    <= count_ext[rlpm_pkg::COUNT_W-1:0];
		end
	end

	assign count_ext = EXT_W'(count_q);

	assign status.filter_on   = filter_q;
	assign status.table_empty = (count_q == '0);
	assign status.cmp_valid   = rd_valid_s1;
	assign status.cmp_last    = rd_last_s1;
	// An entry whose two ends are equal is open above its low end.
	assign status.hit = rd_valid_s1 && (query_q >= QW'(rd_lo_s1)) &&
		((rd_lo_s1 == rd_hi_s1) || (query_q < QW'(rd_hi_s1)));

	assign in_range       = in_range_q;
	assign table_overflow = table_overflow_q;
	assign range_count    = range_count_q;

endmodule

>>> design/range_list_parse_and_match_core.sv
// Top level of the range list parse and match core: controller, datapath and checks.
//
//   channel  | handshake                          | payload
//   ---------+------------------------------------+--------------------------------------
//   item     | item_valid / item_stall            | command, list_char, query_value
//   result   | result_valid / result_stall        | in_range, table_overflow, range_count
//   config   | filter_enable_we                   | filter_enable_wdata
//
// A list character yields no result and leaves the input free for the next transfer. An end
// of list, or a query with the filter off or an empty table, sets the match at its transfer
// and goes to the emit state, which loads the result register once the result slot is free.
// Any other query scans one entry a cycle and stops at the first match or the last entry,
// then passes through the emit state the same way; the input is busy until it is done.
// Reset is asynchronous; after it the filter is off and the table is empty.
// A result waiting under result_stall does not hold up further list characters.
module range_list_parse_and_match_core #(
	parameter int unsigned MAX_RANGES = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    command,
	input  logic [7:0]                    list_char,
	input  logic [rlpm_pkg::QUERY_W-1:0]  query_value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          in_range,
	output logic                          table_overflow,
	output logic [rlpm_pkg::COUNT_W-1:0]  range_count,
	input  logic                          filter_enable_we,
	input  logic                          filter_enable_wdata
);

	rlpm_pkg::dp_cmd_t    cmd;
	rlpm_pkg::dp_status_t status;

	rlpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	rlpm_datapath #(
		.MAX_RANGES (MAX_RANGES)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.filter_enable_we    (filter_enable_we),
		.filter_enable_wdata (filter_enable_wdata),
		.list_char           (list_char),
		.query_value         (query_value),
		.in_range            (in_range),
		.table_overflow      (table_overflow),
		.range_count         (range_count)
	);

	// A transfer that owes a result keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall &&
			(command == rlpm_pkg::CMD_END || command == rlpm_pkg::CMD_QUERY)) |=> item_stall)
		else $error("block not busy after a result-bearing transfer");

	// A list character never blocks the next transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && command == rlpm_pkg::CMD_CHAR) |=> !item_stall)
		else $error("list character left the block busy");

	// The result register is only loaded when its previous content has gone.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid || !result_stall))
		else $error("result register overwritten while stalled");

	// A scan only ever runs against a non-empty table with the filter on.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> (status.filter_on && !status.table_empty))
		else $error("scan started without a usable table");

endmodule
